// ===== rtl/nfcp_pkg.sv =====
// ----------------------------------------------------------------------------
// nfcp_pkg
// Shared types and constants of the response frame parser.
// ----------------------------------------------------------------------------
package nfcp_pkg;

  // largest payload count the parser can ever accept
  localparam int unsigned MAX_PAYLOAD = 264;

  // reset value of the capacity register
  localparam logic [8:0] CAPACITY_RST = 9'd264;

  // byte address of the capacity register
  localparam logic [1:0] ADDR_CAPACITY = 2'd0;

  // frame marker bytes
  localparam logic [7:0] MARK_FF     = 8'hFF;
  localparam logic [7:0] TFI_TO_HOST = 8'hD5;

  // saturated payload count reported on overflow
  localparam logic [8:0] PLEN_SAT = 9'h1FF;

  // report codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_INVALID   = 3'd2,
    ST_BAD_MARK  = 3'd3,
    ST_BAD_LCS   = 3'd4,
    ST_NO_SPACE  = 3'd5
  } status_t;

  // one result beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       frame_done;
    status_t    status;
    logic [8:0] payload_length;
  } result_t;

endpackage

// ===== rtl/nfcp_if.sv =====
// ----------------------------------------------------------------------------
// nfcp_in_if / nfcp_out_if
// Valid/ready channels carrying received bytes and parse results.
// ----------------------------------------------------------------------------
interface nfcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       first_of_read;

  modport source (output valid, output rx_byte, output first_of_read, input ready);
  modport sink   (input valid, input rx_byte, input first_of_read, output ready);
endinterface

interface nfcp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       frame_done;
  logic [2:0] status;
  logic [8:0] payload_length;

  modport source (output valid, output data_byte, output data_valid, output frame_done,
                  output status, output payload_length, input ready);
  modport sink   (input valid, input data_byte, input data_valid, input frame_done,
                  input status, input payload_length, output ready);
endinterface

// ===== rtl/nfcp_cfg.sv =====
// ----------------------------------------------------------------------------
// nfcp_cfg
// APB register slave holding the payload capacity register.
// ----------------------------------------------------------------------------
module nfcp_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [8:0]  capacity
);
  import nfcp_pkg::*;

  logic [8:0] capacity_r;
  logic       addr_hit;
  logic       wr_en;

  // address decode of the single capacity register
  assign addr_hit = (paddr == ADDR_CAPACITY);
  assign wr_en    = psel & penable & pwrite & addr_hit;
  assign pready   = 1'b1;
  assign prdata   = addr_hit ? {23'd0, capacity_r} : 32'd0;
  assign capacity = capacity_r;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RST;
    end else if (wr_en) begin
      capacity_r <= pwdata[8:0];
    end
  end

endmodule

// ===== rtl/nfcp_parse.sv =====
// ----------------------------------------------------------------------------
// nfcp_parse
// Frame state machine: one byte per advance, result formed combinationally.
// ----------------------------------------------------------------------------
module nfcp_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic [7:0]            rx_byte,
  input  logic                  first_of_read,
  input  logic [8:0]            capacity,
  output nfcp_pkg::result_t     result
);
  import nfcp_pkg::*;

  typedef enum logic [12:0] {
    PH_IDLE = 13'b0000000000001,
    PH_PRE  = 13'b0000000000010,
    PH_SC1  = 13'b0000000000100,
    PH_SC2  = 13'b0000000001000,
    PH_LEN  = 13'b0000000010000,
    PH_LENX = 13'b0000000100000,
    PH_LENM = 13'b0000001000000,
    PH_LENL = 13'b0000010000000,
    PH_LCS  = 13'b0000100000000,
    PH_TFI  = 13'b0001000000000,
    PH_DATA = 13'b0010000000000,
    PH_DCS  = 13'b0100000000000,
    PH_POST = 13'b1000000000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] frame_length_r, frame_length_nxt;
  logic [8:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  data_sum_r, data_sum_nxt;
  logic [7:0]  length_high_r, length_high_nxt;

  logic [15:0] fl_m1;
  logic [8:0]  fl_m1_sat;
  logic [8:0]  limit;
  logic [7:0]  lcs_sum;
  logic [7:0]  dcs_sum;

  // length arithmetic shared by several phases
  assign fl_m1     = frame_length_r - 16'd1;
  assign fl_m1_sat = (fl_m1 > 16'(PLEN_SAT)) ? PLEN_SAT : fl_m1[8:0];
  assign limit     = ({7'd0, capacity} < 16'(MAX_PAYLOAD)) ? capacity : 9'(MAX_PAYLOAD);
  assign lcs_sum   = length_high_r + frame_length_r[7:0] + rx_byte;
  assign dcs_sum   = data_sum_r + rx_byte;

  // next state and result
  always_comb begin
    phase_nxt        = phase_r;
    frame_length_nxt = frame_length_r;
    bytes_left_nxt   = bytes_left_r;
    data_sum_nxt     = data_sum_r;
    length_high_nxt  = length_high_r;
    result           = '0;

    if (first_of_read) begin
      if (!rx_byte[0]) begin
        result.frame_done = 1'b1;
        result.status     = ST_NOT_READY;
        phase_nxt         = PH_IDLE;
      end else begin
        frame_length_nxt = '0;
        bytes_left_nxt   = '0;
        data_sum_nxt     = '0;
        length_high_nxt  = '0;
        phase_nxt        = PH_PRE;
      end
    end else begin
      unique case (phase_r)
        PH_PRE, PH_SC1: begin
          if (rx_byte != 8'd0) begin
            result.frame_done = 1'b1;
            result.status     = ST_INVALID;
            phase_nxt         = PH_IDLE;
          end else begin
            phase_nxt = (phase_r == PH_PRE) ? PH_SC1 : PH_SC2;
          end
        end
        PH_SC2: begin
          if (rx_byte != MARK_FF) begin
            result.frame_done = 1'b1;
            result.status     = ST_INVALID;
            phase_nxt         = PH_IDLE;
          end else begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (rx_byte == MARK_FF) begin
            phase_nxt = PH_LENX;
          end else begin
            length_high_nxt  = '0;
            frame_length_nxt = {8'd0, rx_byte};
            phase_nxt        = PH_LCS;
          end
        end
        PH_LENX: begin
          if (rx_byte != MARK_FF) begin
            result.frame_done = 1'b1;
            result.status     = ST_BAD_MARK;
            phase_nxt         = PH_IDLE;
          end else begin
            phase_nxt = PH_LENM;
          end
        end
        PH_LENM: begin
          length_high_nxt = rx_byte;
          phase_nxt       = PH_LENL;
        end
        PH_LENL: begin
          frame_length_nxt = {length_high_r, rx_byte};
          phase_nxt        = PH_LCS;
        end
        PH_LCS: begin
          if (lcs_sum != 8'd0) begin
            result.frame_done = 1'b1;
            result.status     = ST_BAD_LCS;
            phase_nxt         = PH_IDLE;
          end else if (frame_length_r == 16'd0) begin
            // zero length underflows the payload count
            result.frame_done     = 1'b1;
            result.status         = ST_NO_SPACE;
            result.payload_length = PLEN_SAT;
            phase_nxt             = PH_IDLE;
          end else if (fl_m1 > {7'd0, limit}) begin
            result.frame_done     = 1'b1;
            result.status         = ST_NO_SPACE;
            result.payload_length = fl_m1_sat;
            phase_nxt             = PH_IDLE;
          end else begin
            bytes_left_nxt = fl_m1[8:0];
            phase_nxt      = PH_TFI;
          end
        end
        PH_TFI: begin
          if (frame_length_r <= 16'd1) begin
            // length of one: this byte ends the frame unchecked
            result.frame_done = 1'b1;
            result.status     = ST_OK;
            phase_nxt         = PH_IDLE;
          end else if (rx_byte != TFI_TO_HOST) begin
            result.frame_done     = 1'b1;
            result.status         = ST_INVALID;
            result.payload_length = fl_m1_sat;
            phase_nxt             = PH_IDLE;
          end else begin
            data_sum_nxt = TFI_TO_HOST;
            phase_nxt    = PH_DATA;
          end
        end
        PH_DATA: begin
          result.data_byte  = rx_byte;
          result.data_valid = 1'b1;
          data_sum_nxt      = dcs_sum;
          bytes_left_nxt    = bytes_left_r - 9'd1;
          if (bytes_left_r == 9'd1) begin
            phase_nxt = PH_DCS;
          end
        end
        PH_DCS: begin
          if (dcs_sum != 8'd0) begin
            result.frame_done     = 1'b1;
            result.status         = ST_INVALID;
            result.payload_length = fl_m1_sat;
            phase_nxt             = PH_IDLE;
          end else begin
            phase_nxt = PH_POST;
          end
        end
        PH_POST: begin
          // postamble value is not checked
          result.frame_done     = 1'b1;
          result.status         = ST_OK;
          result.payload_length = fl_m1_sat;
          phase_nxt             = PH_IDLE;
        end
        default: begin
          // idle: stray bytes give an empty result
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      frame_length_r <= '0;
      bytes_left_r   <= '0;
      data_sum_r     <= '0;
      length_high_r  <= '0;
    end else if (advance) begin
      phase_r        <= phase_nxt;
      frame_length_r <= frame_length_nxt;
      bytes_left_r   <= bytes_left_nxt;
      data_sum_r     <= data_sum_nxt;
      length_high_r  <= length_high_nxt;
    end
  end

endmodule

// ===== rtl/nfcp_response_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// nfc_response_frame_parser_core
// Deframes host-interface response reads into payload bytes and a status.
// ----------------------------------------------------------------------------
// One byte is taken per beat and every accepted byte yields exactly one
// result beat: a byte goes into an input register, the frame state
// machine works on it combinationally and the result lands in an output
// register. The throughput is one byte per clock while the receiver is
// ready; a stalled output holds both registers and backs up to in_ch.ready.
// Payload bytes come out with data_valid; the byte that ends
// a frame or hits an error carries frame_done and the status. A status
// byte (first_of_read) restarts parsing at any point. The capacity
// register sits at byte address 0 of the APB port.
module nfc_response_frame_parser_core (
  input  logic              clk,
  input  logic              rst_n,
  nfcp_in_if.sink           in_ch,
  nfcp_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import nfcp_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_first_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    parse_res;
  logic [8:0] capacity;
  logic       out_adv;
  logic       s1_fire;
  logic       in_fire;

  // register slave
  nfcp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // pipeline flow control
  assign out_adv     = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_adv;
  assign in_ch.ready = !s1_valid_r || out_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_ch.rx_byte;
      s1_first_r <= in_ch.first_of_read;
    end
  end

  // frame state machine
  nfcp_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (s1_fire),
    .rx_byte       (s1_byte_r),
    .first_of_read (s1_first_r),
    .capacity      (capacity),
    .result        (parse_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= parse_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.data_byte      = out_res_r.data_byte;
  assign out_ch.data_valid     = out_res_r.data_valid;
  assign out_ch.frame_done     = out_res_r.frame_done;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.payload_length = out_res_r.payload_length;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the response frame parser core.
// ----------------------------------------------------------------------------
// Host-interface response reads are built byte by byte: well-formed normal
// and extended frames, plus frames with a broken status, preamble, start
// code, length marker, length checksum, TFI or data checksum, cut and
// bit-flipped frames and stray bytes. Every accepted byte runs through a
// bench-side deframer that predicts its result beat. A checker compares each
// result beat field by field with the oldest prediction. The capacity
// register is read back after reset and rewritten between phases with
// different sender idle and receiver stall rates.
// ----------------------------------------------------------------------------
module testbench;
  import nfcp_pkg::*;

  // deframer phases through the fields of a frame
  typedef enum logic [3:0] {
    PH_IDLE, PH_PRE, PH_SC1, PH_SC2, PH_LEN, PH_LENX, PH_LENM, PH_LENL,
    PH_LCS, PH_TFI, PH_DATA, PH_DCS, PH_POST
  } parse_phase_t;

  // ways a generated frame can be damaged
  typedef enum int {
    FLAW_NONE, FLAW_NOT_READY, FLAW_PREAMBLE, FLAW_START, FLAW_MARKER,
    FLAW_LCS, FLAW_TFI, FLAW_DCS, FLAW_CUT, FLAW_FLIP
  } flaw_t;

  localparam logic [1:0] CAPACITY_ADDR = 2'd0;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  nfcp_in_if  in_ch ();
  nfcp_out_if out_ch ();

  nfc_response_frame_parser_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // deframer state and capacity copy
  parse_phase_t rx_phase  = PH_IDLE;
  logic [15:0]  len_field = '0;
  logic [8:0]   remain    = '0;
  logic [7:0]   sum_acc   = '0;
  logic [7:0]   len_msb   = '0;
  logic [8:0]   cap_reg   = CAPACITY_RST;

  result_t     expected_q[$];
  result_t     want;
  int unsigned beats_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  int          idle_pct     = 0;
  int          stall_pct    = 0;

  task automatic report(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  // close the frame with a status and a saturated payload count
  function automatic result_t frame_end(input status_t st, input int unsigned plen);
    result_t r;
    r = '0;
    r.frame_done = 1'b1;
    r.status = st;
    r.payload_length = (plen > 511) ? PLEN_SAT : plen[8:0];
    rx_phase = PH_IDLE;
    return r;
  endfunction

  function automatic int unsigned payload_limit();
    return (cap_reg < MAX_PAYLOAD) ? cap_reg : MAX_PAYLOAD;
  endfunction

  // expected result of one accepted byte
  function automatic result_t deframe_step(input logic [7:0] b, input logic is_start);
    result_t     r;
    logic [7:0]  chk;
    int unsigned cnt;
    r = '0;
    if (is_start) begin
      if (!b[0]) return frame_end(ST_NOT_READY, 0);
      len_field = '0;
      remain = '0;
      sum_acc = '0;
      len_msb = '0;
      rx_phase = PH_PRE;
      return r;
    end
    case (rx_phase)
      PH_PRE: begin
        if (b != 8'h00) return frame_end(ST_INVALID, 0);
        rx_phase = PH_SC1;
      end
      PH_SC1: begin
        if (b != 8'h00) return frame_end(ST_INVALID, 0);
        rx_phase = PH_SC2;
      end
      PH_SC2: begin
        if (b != MARK_FF) return frame_end(ST_INVALID, 0);
        rx_phase = PH_LEN;
      end
      PH_LEN: begin
        if (b == MARK_FF) begin
          rx_phase = PH_LENX;
        end else begin
          len_msb = '0;
          len_field = {8'h00, b};
          rx_phase = PH_LCS;
        end
      end
      PH_LENX: begin
        if (b != MARK_FF) return frame_end(ST_BAD_MARK, 0);
        rx_phase = PH_LENM;
      end
      PH_LENM: begin
        len_msb = b;
        rx_phase = PH_LENL;
      end
      PH_LENL: begin
        len_field = {len_msb, b};
        rx_phase = PH_LCS;
      end
      PH_LCS: begin
        chk = len_msb + len_field[7:0] + b;
        if (chk != 8'h00) return frame_end(ST_BAD_LCS, 0);
        // zero length underflows the payload count
        if (len_field == 16'd0) return frame_end(ST_NO_SPACE, PLEN_SAT);
        cnt = len_field - 1;
        if (cnt > payload_limit()) return frame_end(ST_NO_SPACE, cnt);
        remain = cnt[8:0];
        rx_phase = PH_TFI;
      end
      PH_TFI: begin
        // length one ends on this byte without checking it
        if (len_field <= 16'd1) return frame_end(ST_OK, 0);
        if (b != TFI_TO_HOST) return frame_end(ST_INVALID, len_field - 1);
        sum_acc = TFI_TO_HOST;
        rx_phase = PH_DATA;
      end
      PH_DATA: begin
        r.data_byte = b;
        r.data_valid = 1'b1;
        sum_acc = sum_acc + b;
        remain = remain - 9'd1;
        if (remain == 9'd0) rx_phase = PH_DCS;
      end
      PH_DCS: begin
        chk = sum_acc + b;
        if (chk != 8'h00) return frame_end(ST_INVALID, len_field - 1);
        rx_phase = PH_POST;
      end
      PH_POST: begin
        return frame_end(ST_OK, len_field - 1);
      end
      default: begin
        rx_phase = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  // one input beat, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic is_start);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.first_of_read <= is_start;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(deframe_step(b, is_start));
    beats_sent++;
  endtask

  // stop sending and let every predicted result come out
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [8:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= {23'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_reg = val;
    @(posedge clk);
  endtask

  task automatic apb_read_check(input logic [8:0] val);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CAPACITY_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== {23'd0, val})
      report($sformatf("capacity readback got %0d want %0d", got, val));
    @(posedge clk);
  endtask

  task automatic set_capacity(input logic [8:0] val);
    wait_all_results();
    apb_write(val);
    apb_read_check(val);
  endtask

  function automatic logic [7:0] nonzero_byte();
    return 8'($urandom_range(255, 1));
  endfunction

  // build one read transaction for a given length field and send it
  task automatic send_frame(input int unsigned len_val, input bit ext, input flaw_t flaw);
    logic [8:0]  seq[$];
    logic [7:0]  b;
    logic [7:0]  dsum;
    logic [15:0] len16;
    int unsigned keep;
    int unsigned pos;
    bit          body;
    len16 = len_val[15:0];
    b = 8'($urandom);
    b[0] = (flaw != FLAW_NOT_READY);
    seq.push_back({1'b1, b});
    if (flaw != FLAW_NOT_READY) begin
      // preamble and start codes
      seq.push_back({1'b0, (flaw == FLAW_PREAMBLE) ? nonzero_byte() : 8'h00});
      if (flaw == FLAW_START && $urandom_range(1) == 1) begin
        seq.push_back({1'b0, nonzero_byte()});
      end else begin
        seq.push_back({1'b0, 8'h00});
        seq.push_back({1'b0, (flaw == FLAW_START) ? 8'($urandom_range(254)) : MARK_FF});
      end
      // length header
      if (len_val > 254) ext = 1'b1;
      if (ext) begin
        seq.push_back({1'b0, MARK_FF});
        seq.push_back({1'b0, (flaw == FLAW_MARKER) ? 8'($urandom_range(254)) : MARK_FF});
        seq.push_back({1'b0, len16[15:8]});
        seq.push_back({1'b0, len16[7:0]});
        b = 8'd0 - len16[15:8] - len16[7:0];
      end else begin
        seq.push_back({1'b0, len16[7:0]});
        b = 8'd0 - len16[7:0];
      end
      if (flaw == FLAW_LCS) b = b + nonzero_byte();
      seq.push_back({1'b0, b});
      body = !(flaw inside {FLAW_PREAMBLE, FLAW_START, FLAW_MARKER, FLAW_LCS})
             && len16 != 16'd0 && (len16 - 1) <= payload_limit();
      if (body && len16 == 16'd1) begin
        seq.push_back({1'b0, 8'($urandom)});
      end else if (body) begin
        seq.push_back({1'b0, (flaw == FLAW_TFI) ? TFI_TO_HOST ^ nonzero_byte() : TFI_TO_HOST});
        dsum = TFI_TO_HOST;
        for (int unsigned i = 1; i < len16; i++) begin
          b = 8'($urandom);
          dsum = dsum + b;
          seq.push_back({1'b0, b});
        end
        b = 8'd0 - dsum;
        if (flaw == FLAW_DCS) b = b + nonzero_byte();
        seq.push_back({1'b0, b});
        // postamble is not checked
        seq.push_back({1'b0, ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00});
      end
    end
    // cut short or corrupt one byte past the status
    if (flaw == FLAW_CUT && seq.size() > 2) begin
      keep = $urandom_range(seq.size() - 1, 1);
      while (seq.size() > keep) seq.delete(seq.size() - 1);
    end
    if (flaw == FLAW_FLIP && seq.size() > 1) begin
      pos = $urandom_range(seq.size() - 1, 1);
      seq[pos][7:0] = seq[pos][7:0] ^ nonzero_byte();
    end
    foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8]);
  endtask

  task automatic send_stray_bytes(input int unsigned n);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat %0d with nothing expected", results_seen));
      end else begin
        want = expected_q.pop_front();
        if (out_ch.data_byte !== want.data_byte)
          report($sformatf("beat %0d data_byte got %0h want %0h",
                           results_seen, out_ch.data_byte, want.data_byte));
        if (out_ch.data_valid !== want.data_valid)
          report($sformatf("beat %0d data_valid got %0b want %0b",
                           results_seen, out_ch.data_valid, want.data_valid));
        if (out_ch.frame_done !== want.frame_done)
          report($sformatf("beat %0d frame_done got %0b want %0b",
                           results_seen, out_ch.frame_done, want.frame_done));
        if (out_ch.status !== want.status)
          report($sformatf("beat %0d status got %0d want %0d",
                           results_seen, out_ch.status, want.status));
        if (out_ch.payload_length !== want.payload_length)
          report($sformatf("beat %0d payload_length got %0d want %0d",
                           results_seen, out_ch.payload_length, want.payload_length));
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic test_reset_value();
    apb_read_check(CAPACITY_RST);
  endtask

  // one of each frame kind and each error but the bit flip, at full rate
  task automatic test_directed_frames();
    idle_pct = 0;
    stall_pct = 0;
    send_frame(2, 1'b0, FLAW_NONE);
    send_frame(3, 1'b1, FLAW_NONE);
    send_frame(1, 1'b0, FLAW_NONE);
    send_frame(0, 1'b0, FLAW_NONE);
    send_frame(32'hFFFF, 1'b1, FLAW_NONE);
    send_frame(2, 1'b0, FLAW_NOT_READY);
    send_frame(2, 1'b0, FLAW_PREAMBLE);
    send_frame(2, 1'b0, FLAW_START);
    send_frame(2, 1'b1, FLAW_MARKER);
    send_frame(2, 1'b0, FLAW_LCS);
    send_frame(2, 1'b0, FLAW_TFI);
    send_frame(3, 1'b0, FLAW_DCS);
    send_stray_bytes(2);
    send_frame(4, 1'b0, FLAW_CUT);
    send_frame(2, 1'b0, FLAW_NONE);
  endtask

  // payload counts at and just over the capacity or the MAX_PAYLOAD ceiling
  task automatic test_capacity_limits();
    set_capacity(9'd0);
    send_frame(1, 1'b0, FLAW_NONE);
    send_frame(2, 1'b0, FLAW_NONE);
    set_capacity(9'd1);
    send_frame(2, 1'b0, FLAW_NONE);
    send_frame(3, 1'b1, FLAW_NONE);
    set_capacity(9'd264);
    send_frame(265, 1'b1, FLAW_NONE);
    send_frame(266, 1'b1, FLAW_NONE);
    set_capacity(9'd511);
    send_frame(266, 1'b1, FLAW_NONE);
  endtask

  // mostly well-formed frames with random content, some damaged ones
  task automatic test_random_traffic(input logic [8:0] cap, input int sender_idle,
                                     input int recv_stall, input int unsigned n_items);
    int unsigned start;
    int unsigned lim;
    int unsigned n;
    int unsigned pick;
    int unsigned sz;
    flaw_t       flaw;
    set_capacity(cap);
    idle_pct = sender_idle;
    stall_pct = recv_stall;
    start = beats_sent;
    lim = payload_limit();
    while (beats_sent - start < n_items) begin
      pick = $urandom_range(99);
      sz = $urandom_range(99);
      if (sz < 4) n = $urandom_range(lim + 2);
      else if (sz < 12) n = lim + $urandom_range(1);
      else n = $urandom_range((lim < 12) ? lim + 1 : 12);
      if (pick < 3) wait_all_results();
      if (pick >= 95) begin
        send_stray_bytes($urandom_range(4, 1));
      end else begin
        flaw = (pick < 70) ? FLAW_NONE : flaw_t'($urandom_range(FLAW_FLIP, FLAW_NOT_READY));
        send_frame((pick >= 88) ? $urandom_range(1) : n + 1, $urandom_range(3) == 0, flaw);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= '0;
    in_ch.first_of_read <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_value();
    test_directed_frames();
    test_capacity_limits();
    test_random_traffic(9'd264, 0, 0, 120);
    test_random_traffic(9'd511, 54, 0, 120);
    test_random_traffic(9'($urandom_range(264, 2)), 0, 54, 120);
    test_random_traffic(9'd40, 15, 15, 120);

    wait_all_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nfcp_pkg.sv
rtl/nfcp_if.sv
rtl/nfcp_cfg.sv
rtl/nfcp_parse.sv
rtl/nfcp_response_frame_parser_core.sv
tb/sv/testbench.sv
